/* rtl/core/ost_pkg.sv */
// Package for the ordered sequence table: request/response payload types,
// operation and status codes, and default sizes. No dependencies.
`default_nettype none

package ost_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int DATA_W_DEF = 32;

  localparam int MODE_W = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 7;
  localparam int DAT_W  = 32;
  localparam int CNT_W  = 7;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SINS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ERA  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GET  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SET  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FIND = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index;
    logic [DAT_W-1:0]  data;
    logic [CNT_W-1:0]  count;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/ordered_sequence_table.sv */
// Ordered sequence table: positional list of DEPTH words kept in one
// synchronous RAM, with a read-modify-write sequencer. Uses ost_pkg.
// Get and set finish after a single RAM access; insert, erase, remove and find
// sweep the entries they scan or move, a sorted insert at the front of a nearly
// full list being the longest case.
// Throughput: one request at a time; the next request is taken once the result
// has been loaded into the output register, even if that result is still stalled.
// Reset: asynchronous, clears the entry count and all control; RAM is not cleared.
`default_nettype none

module ordered_sequence_table #(
  parameter int DEPTH  = ost_pkg::DEPTH_DEF,
  parameter int DATA_W = ost_pkg::DATA_W_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  ost_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output ost_pkg::rsp_t  out_data_o
);

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int AddrW = $clog2(DEPTH);
  localparam int CmpW  = (CntW > ost_pkg::POS_W) ? CntW : ost_pkg::POS_W;
  localparam int IdxW  = ost_pkg::IDX_W;
  localparam int DatW  = ost_pkg::DAT_W;
  localparam int OutCW = ost_pkg::CNT_W;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // wait for a request
    S_SCAN = 6'b000010,  // forward sweep: sorted search, find, remove-all
    S_SHUP = 6'b000100,  // move entries up by one, then place the new word
    S_SHDN = 6'b001000,  // move entries down by one to close a gap
    S_GET  = 6'b010000,  // read data returns
    S_DONE = 6'b100000   // result waits for the output register
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;        // entries held
  logic [CntW-1:0]    ptr_q, ptr_d;        // next read pointer
  logic [CntW-1:0]    ra_q, ra_d;          // address of the word in rdata_q
  logic               rv_q, rv_d;          // rdata_q holds a word to process
  logic [CntW-1:0]    k_q, k_d;            // compaction write pointer
  logic [CntW-1:0]    ins_pos_q, ins_pos_d;
  logic [ost_pkg::MODE_W-1:0] op_q, op_d;
  logic [DATA_W-1:0]  val_q, val_d;
  ost_pkg::rsp_t      res_q, res_d;
  ost_pkg::rsp_t      out_q, out_d;
  logic               out_vld_q, out_vld_d;

  // RAM ports
  logic [DATA_W-1:0]  mem_q [DEPTH];
  logic [DATA_W-1:0]  rdata_q;
  logic               we, re;
  logic [AddrW-1:0]   waddr, raddr;
  logic [DATA_W-1:0]  wdata;

  logic               in_xfer;
  logic [DATA_W-1:0]  v_in;
  logic [CmpW-1:0]    pos_x, cnt_x;
  logic               full;
  logic               hit;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign v_in  = DATA_W'(in_data_i.value);
  assign pos_x = CmpW'(in_data_i.position);
  assign cnt_x = CmpW'(cnt_q);
  assign full  = (cnt_q == CntW'(DEPTH));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    ra_d      = ra_q;
    rv_d      = rv_q;
    k_d       = k_q;
    ins_pos_d = ins_pos_q;
    op_d      = op_q;
    val_d     = val_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = '0;
    raddr     = '0;
    wdata     = '0;
    hit       = 1'b0;

    // Drop the result once the consumer takes it.
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          val_d        = v_in;
          op_d         = in_data_i.mode;
          rv_d         = 1'b0;
          res_d        = '0;
          res_d.status = ost_pkg::ST_OK;
          case (in_data_i.mode)
            ost_pkg::MODE_INS: begin
              if (pos_x > cnt_x) begin
                res_d.status = ost_pkg::ST_BAD;
                state_d      = S_DONE;
              end else if (full) begin
                res_d.status = ost_pkg::ST_FULL;
                state_d      = S_DONE;
              end else begin
                ins_pos_d = CntW'(in_data_i.position);
                ptr_d     = cnt_q;
                state_d   = S_SHUP;
              end
            end
            ost_pkg::MODE_SINS: begin
              if (full) begin
                res_d.status = ost_pkg::ST_FULL;
                state_d      = S_DONE;
              end else begin
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            ost_pkg::MODE_ERA: begin
              if (pos_x >= cnt_x) begin
                res_d.status = ost_pkg::ST_BAD;
                state_d      = S_DONE;
              end else begin
                ptr_d   = CntW'(in_data_i.position) + CntW'(1);
                state_d = S_SHDN;
              end
            end
            ost_pkg::MODE_REM,
            ost_pkg::MODE_FIND: begin
              ptr_d   = '0;
              k_d     = '0;
              state_d = S_SCAN;
            end
            ost_pkg::MODE_GET: begin
              if (pos_x >= cnt_x) begin
                res_d.status = ost_pkg::ST_BAD;
                state_d      = S_DONE;
              end else begin
                re      = 1'b1;
                raddr   = AddrW'(in_data_i.position);
                state_d = S_GET;
              end
            end
            ost_pkg::MODE_SET: begin
              if (pos_x >= cnt_x) begin
                res_d.status = ost_pkg::ST_BAD;
              end else begin
                we    = 1'b1;
                waddr = AddrW'(in_data_i.position);
                wdata = v_in;
              end
              state_d = S_DONE;
            end
            default: begin
              res_d.status = ost_pkg::ST_BAD;
              state_d      = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Check the word that came back from last cycle's read.
        if (rv_q) begin
          case (op_q)
            ost_pkg::MODE_SINS: hit = (val_q <= rdata_q);
            ost_pkg::MODE_FIND: hit = (val_q == rdata_q);
            default: begin
              // remove-all: keep non-matching words, packed toward the front
              if (rdata_q != val_q) begin
                we    = 1'b1;
                waddr = AddrW'(k_q);
                wdata = rdata_q;
                k_d   = k_q + CntW'(1);
              end
            end
          endcase
        end
        if (hit) begin
          rv_d = 1'b0;
          if (op_q == ost_pkg::MODE_SINS) begin
            ins_pos_d = ra_q;
            ptr_d     = cnt_q;
            state_d   = S_SHUP;
          end else begin
            res_d.index = IdxW'(ra_q);
            state_d     = S_DONE;
          end
        end else if (ptr_q != cnt_q) begin
          re    = 1'b1;
          raddr = AddrW'(ptr_q);
          ra_d  = ptr_q;
          rv_d  = 1'b1;
          ptr_d = ptr_q + CntW'(1);
        end else begin
          rv_d = 1'b0;
          case (op_q)
            ost_pkg::MODE_SINS: begin
              ins_pos_d = cnt_q;
              ptr_d     = cnt_q;
              state_d   = S_SHUP;
            end
            ost_pkg::MODE_FIND: begin
              res_d.status = ost_pkg::ST_BAD;
              state_d      = S_DONE;
            end
            default: begin
              cnt_d       = k_d;
              res_d.index = IdxW'(cnt_q - k_d);
              state_d     = S_DONE;
            end
          endcase
        end
      end

      S_SHUP: begin
        // Walk down from the top: read entry n-1, write it to n next cycle.
        if (rv_q) begin
          we    = 1'b1;
          waddr = AddrW'(ra_q + CntW'(1));
          wdata = rdata_q;
        end
        if (ptr_q > ins_pos_q) begin
          re    = 1'b1;
          raddr = AddrW'(ptr_q - CntW'(1));
          ra_d  = ptr_q - CntW'(1);
          rv_d  = 1'b1;
          ptr_d = ptr_q - CntW'(1);
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            we          = 1'b1;
            waddr       = AddrW'(ins_pos_q);
            wdata       = val_q;
            cnt_d       = cnt_q + CntW'(1);
            res_d.index = IdxW'(ins_pos_q);
            state_d     = S_DONE;
          end
        end
      end

      S_SHDN: begin
        // Walk up from the gap: read entry n, write it to n-1 next cycle.
        if (rv_q) begin
          we    = 1'b1;
          waddr = AddrW'(ra_q - CntW'(1));
          wdata = rdata_q;
        end
        if (ptr_q != cnt_q) begin
          re    = 1'b1;
          raddr = AddrW'(ptr_q);
          ra_d  = ptr_q;
          rv_d  = 1'b1;
          ptr_d = ptr_q + CntW'(1);
        end else begin
          rv_d    = 1'b0;
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_DONE;
        end
      end

      S_GET: begin
        res_d.data = DatW'(rdata_q);
        state_d    = S_DONE;
      end

      S_DONE: begin
        // Load the output register once it is free or being emptied.
        if (!out_vld_q || !out_stall_i) begin
          out_d       = res_q;
          out_d.count = OutCW'(cnt_q);
          out_vld_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      ptr_q     <= '0;
      rv_q      <= 1'b0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ptr_q     <= ptr_d;
      rv_q      <= rv_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ra_q      <= ra_d;
    ins_pos_q <= ins_pos_d;
    op_q      <= op_d;
    val_q     <= val_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Entry RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Entry count never exceeds the table size.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above DEPTH");

  // Moves never read and write the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("RAM read and write hit the same entry");

  // Count only changes as an operation completes.
  a_cnt_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (state_q == S_DONE))
    else $error("entry count changed outside completion");

  // A request is only taken with the sequencer idle.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> !($past(in_xfer)))
    else $error("request transfer while busy");

endmodule

`default_nettype wire
